### hdl/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
package pli_pkg;
   localparam int TableDepth = 32;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = 6;
   localparam int DataW = 32;
   localparam int QueueDepth = 2;
   localparam int QPtrW = 1;
   localparam int ProdW = 65;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // one word passed from the front part to the back part
   typedef struct packed {
      logic opcode;
      logic [IdxW-1:0] entry_index;
      logic signed [DataW-1:0] x_value;
      logic signed [DataW-1:0] y_value;
   } cmd_type;
endpackage

### hdl/pli_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module pli_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### hdl/pli_front.sv
// Front part: takes command words into a short queue.
module pli_front (
   input logic clock,
   input logic reset,
   input logic push,
   input pli_pkg::cmd_type push_word,
   output logic full,
   input logic pop,
   output logic empty,
   output pli_pkg::cmd_type head
);
   import pli_pkg::*;

   cmd_type q_ff [QueueDepth];
   logic [QPtrW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QPtrW:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == (QPtrW+1)'(QueueDepth));
   assign empty = (cnt_ff == '0);
   assign head = q_ff[rp_ff];

   // pointer and count update
   always_comb begin
      wp_in = wp_ff + QPtrW'(push);
      rp_in = rp_ff + QPtrW'(pop);
      cnt_in = cnt_ff + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= push_word;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue underflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPtrW+1)'(QueueDepth)) else $error("queue count out of range");
`endif
endmodule

### hdl/pli_back.sv
// Back part: table writes, segment scan, serial divide, saturation.
module pli_back (
   input logic clock,
   input logic reset,
   input logic [pli_pkg::CntW-1:0] n_cfg,
   input logic cmd_valid,
   input pli_pkg::cmd_type cmd,
   output logic cmd_pop,
   output logic idle,
   output logic res_valid,
   output logic signed [pli_pkg::DataW-1:0] res_y
);
   import pli_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD_FIRST = 4'd1;
   localparam logic [3:0] S_CHK_FIRST = 4'd2;
   localparam logic [3:0] S_CHK_LAST = 4'd3;
   localparam logic [3:0] S_SCAN = 4'd4;
   localparam logic [3:0] S_FETCH0 = 4'd5;
   localparam logic [3:0] S_FETCH1 = 4'd6;
   localparam logic [3:0] S_LOAD = 4'd7;
   localparam logic [3:0] S_MUL = 4'd8;
   localparam logic [3:0] S_DIV = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;
   localparam logic [3:0] S_ONE = 4'd12;
   localparam int RemW = DataW + 2;
   localparam int StepW = $clog2(ProdW + 1);

   logic [3:0] st_ff, st_in;
   logic signed [DataW-1:0] xq_ff, xq_in;
   logic [CntW-1:0] n_ff, n_in;
   logic [IdxW-1:0] k_ff, k_in, seg_ff, seg_in;
   logic signed [DataW-1:0] xprev_ff, xprev_in, x0_ff, x0_in, y0_ff, y0_in;
   logic [DataW:0] md_ff, mdy_ff, mdx_ff, md_in, mdy_in, mdx_in;
   logic neg_ff, neg_in, trivial_ff, trivial_in;
   logic [ProdW-1:0] num_ff, num_in;
   logic [RemW-1:0] rem_ff, rem_in;
   logic [ProdW-1:0] quo_ff, quo_in;
   logic [StepW-1:0] step_ff, step_in;
   logic rv_ff, rv_in;
   logic signed [DataW-1:0] ry_ff, ry_in;

   logic wr_en;
   logic [IdxW-1:0] rd_addr;
   logic signed [DataW-1:0] x_rd, y_rd;

   // breakpoint stores
   pli_ram #(.Width(DataW), .Depth(TableDepth)) u_xram (
      .clock(clock), .wr_en(wr_en), .wr_addr(cmd.entry_index), .wr_data(cmd.x_value),
      .rd_addr(rd_addr), .rd_data(x_rd));
   pli_ram #(.Width(DataW), .Depth(TableDepth)) u_yram (
      .clock(clock), .wr_en(wr_en), .wr_addr(cmd.entry_index), .wr_data(cmd.y_value),
      .rd_addr(rd_addr), .rd_data(y_rd));

   assign res_valid = rv_ff;
   assign res_y = ry_ff;
   assign idle = (st_ff == S_IDLE);

   logic [CntW-1:0] n_eff;
   logic signed [DataW:0] dx_s, dy_s, d_s;
   logic [RemW-1:0] rem_sh;
   logic signed [ProdW:0] sum_s;

   // sequencer
   always_comb begin
      st_in = st_ff; xq_in = xq_ff; n_in = n_ff; k_in = k_ff; seg_in = seg_ff;
      xprev_in = xprev_ff; x0_in = x0_ff; y0_in = y0_ff;
      md_in = md_ff; mdy_in = mdy_ff; mdx_in = mdx_ff; neg_in = neg_ff;
      trivial_in = trivial_ff; num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff;
      step_in = step_ff; rv_in = 1'b0; ry_in = ry_ff;
      cmd_pop = 1'b0; wr_en = 1'b0; rd_addr = k_ff;
      n_eff = (n_cfg > CntW'(TableDepth)) ? CntW'(TableDepth) : n_cfg;
      dx_s = '0; dy_s = '0; d_s = '0; rem_sh = '0; sum_s = '0;
      case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.opcode == OP_WRITE) begin
                  wr_en = 1'b1;
               end else begin
                  xq_in = cmd.x_value;
                  n_in = n_eff;
                  if (n_eff == '0) begin
                     rv_in = 1'b1; ry_in = '0;
                  end else if (n_eff == CntW'(1)) begin
                     rd_addr = '0; st_in = S_ONE;
                  end else begin
                     rd_addr = '0; st_in = S_RD_FIRST;
                  end
               end
            end
         end
         S_ONE: begin
            rv_in = 1'b1; ry_in = y_rd; st_in = S_IDLE;
         end
         S_RD_FIRST: begin
            // read last entry while checking first
            rd_addr = IdxW'(n_ff - CntW'(1));
            st_in = S_CHK_FIRST;
            if (xq_ff <= x_rd) begin
               seg_in = '0; st_in = S_FETCH0;
            end
         end
         S_CHK_FIRST: begin
            if (xq_ff >= x_rd) begin
               seg_in = IdxW'(n_ff - CntW'(2)); st_in = S_FETCH0;
            end else begin
               rd_addr = '0; k_in = '0; st_in = S_CHK_LAST;
            end
         end
         S_CHK_LAST: begin
            // x[0] arrives; start scan at entry 1
            xprev_in = x_rd; rd_addr = IdxW'(1); k_in = IdxW'(1); st_in = S_SCAN;
         end
         S_SCAN: begin
            // x_rd is x[k]; test segment k-1
            if (xq_ff >= xprev_ff && xq_ff <= x_rd) begin
               seg_in = k_ff - IdxW'(1); st_in = S_FETCH0;
            end else if ({1'b0, k_ff} + 6'(1) >= 6'(n_ff)) begin
               seg_in = IdxW'(n_ff - CntW'(2)); st_in = S_FETCH0;
            end else begin
               xprev_in = x_rd; k_in = k_ff + IdxW'(1); rd_addr = k_ff + IdxW'(1);
            end
         end
         S_FETCH0: begin
            rd_addr = seg_ff; st_in = S_FETCH1;
         end
         S_FETCH1: begin
            rd_addr = seg_ff + IdxW'(1);
            x0_in = x_rd; y0_in = y_rd; st_in = S_LOAD;
         end
         S_LOAD: begin
            dx_s = (DataW+1)'(x_rd) - (DataW+1)'(x0_ff);
            dy_s = (DataW+1)'(y_rd) - (DataW+1)'(y0_ff);
            d_s = (DataW+1)'(xq_ff) - (DataW+1)'(x0_ff);
            trivial_in = (dx_s == '0) || (dy_s == '0) || (d_s == '0);
            neg_in = (d_s[DataW] ^ dy_s[DataW]) ^ dx_s[DataW];
            md_in = d_s[DataW] ? (DataW+1)'(-d_s) : (DataW+1)'(d_s);
            mdy_in = dy_s[DataW] ? (DataW+1)'(-dy_s) : (DataW+1)'(dy_s);
            mdx_in = dx_s[DataW] ? (DataW+1)'(-dx_s) : (DataW+1)'(dx_s);
            st_in = S_MUL;
         end
         S_MUL: begin
            if (trivial_ff) begin
               rv_in = 1'b1; ry_in = y0_ff; st_in = S_IDLE;
            end else begin
               num_in = ProdW'(md_ff) * ProdW'(mdy_ff);
               rem_in = '0; quo_in = '0; step_in = StepW'(ProdW); st_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring division, one bit a cycle
            rem_sh = {rem_ff[RemW-2:0], num_ff[ProdW-1]};
            num_in = num_ff << 1;
            if (rem_sh >= RemW'(mdx_ff)) begin
               rem_in = rem_sh - RemW'(mdx_ff); quo_in = {quo_ff[ProdW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh; quo_in = {quo_ff[ProdW-2:0], 1'b0};
            end
            step_in = step_ff - StepW'(1);
            if (step_ff == StepW'(1)) st_in = S_DONE;
         end
         S_DONE: begin
            sum_s = neg_ff ? ((ProdW+1)'(y0_ff) - $signed({1'b0, quo_ff}))
                           : ((ProdW+1)'(y0_ff) + $signed({1'b0, quo_ff}));
            if (sum_s > (ProdW+1)'(32'sh7fffffff)) ry_in = 32'sh7fffffff;
            else if (sum_s < -(ProdW+1)'(64'sh80000000)) ry_in = 32'sh80000000;
            else ry_in = sum_s[DataW-1:0];
            rv_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
      xq_ff <= xq_in; n_ff <= n_in; k_ff <= k_in; seg_ff <= seg_in;
      xprev_ff <= xprev_in; x0_ff <= x0_in; y0_ff <= y0_in;
      md_ff <= md_in; mdy_ff <= mdy_in; mdx_ff <= mdx_in; neg_ff <= neg_in;
      trivial_ff <= trivial_in; num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in;
      step_ff <= step_in; ry_ff <= ry_in;
   end

`ifndef ASSERT_OFF
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (st_ff == S_IDLE)) else $error("pop outside idle");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DIV) |-> (mdx_ff != '0)) else $error("divide by zero");
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DONE) |=> rv_ff) else $error("missing result");
`endif
endmodule

### hdl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator top level: queue front, compute back.
// A query first tests both ends of the table, then scans the breakpoint RAM
// one table entry per cycle. Fetch and set-up states follow (FETCH0, FETCH1,
// LOAD, MUL), then the bit-serial divider. When the step, the slope or the
// offset is zero the divider is skipped. An empty table answers zero and a
// single entry answers its y value, both without the search. The back part
// takes a write without leaving its idle state. A two-word queue holds
// commands while busy is low; busy rises when it is full. Each result shows
// for one cycle on rsp_valid. The receiver cannot stall. No clearing pass
// after reset.
module piecewise_linear_interpolator (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic req_opcode,
   input logic [pli_pkg::IdxW-1:0] req_entry_index,
   input logic signed [pli_pkg::DataW-1:0] req_x_value,
   input logic signed [pli_pkg::DataW-1:0] req_y_value,
   input logic csr_wr_en,
   input logic [pli_pkg::CntW-1:0] csr_wr_data,
   output logic rsp_valid,
   output logic signed [pli_pkg::DataW-1:0] rsp_y_result
);
   import pli_pkg::*;

   logic [CntW-1:0] n_ff;
   cmd_type in_word, head;
   logic full, empty, pop, idle;

   // points_in_use register
   always_ff @(posedge clock) begin
      if (reset) n_ff <= '0;
      else if (csr_wr_en) n_ff <= csr_wr_data;
   end

   assign busy = full;
   assign in_word = '{opcode: req_opcode, entry_index: req_entry_index,
                      x_value: req_x_value, y_value: req_y_value};

   pli_front u_front (
      .clock(clock), .reset(reset), .push(start && !full), .push_word(in_word),
      .full(full), .pop(pop), .empty(empty), .head(head));

   pli_back u_back (
      .clock(clock), .reset(reset), .n_cfg(n_ff), .cmd_valid(!empty), .cmd(head),
      .cmd_pop(pop), .idle(idle), .res_valid(rsp_valid), .res_y(rsp_y_result));

`ifndef ASSERT_OFF
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      (idle && !empty) |-> pop) else $error("idle back part ignored work");
   a_accept_nobusy: assert property (@(posedge clock) disable iff (reset)
      (start && busy) |=> $stable(n_ff) || $past(csr_wr_en)) else $error("bad state");
   a_result_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_y_result)) else $error("unknown result");
`endif
endmodule
